[design/skvs_pkg.sv]
package skvs_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;

    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // what a cell shows to its upper neighbor and to the result logic
    typedef struct packed {
        logic                    valid;
        logic                    lt;
        logic                    eq;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } cell_out_t;

    // command broadcast to every cell in the apply cycle
    typedef struct packed {
        logic                    insert;
        logic                    update;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } apply_cmd_t;

    localparam cell_out_t CELL_EDGE = '{valid: 1'b0, lt: 1'b1, eq: 1'b0,
                                        key: '0, value: '0};

endpackage

[design/sorted_key_value_store_unit.sv]
// Sorted key-value store of 64 entries held in a row of cells, kept in
// ascending signed key order. In the cycle a request is accepted every cell
// compares its key with the request key, and when the store goes through its
// apply cycle the cells above the insert point shift up by one (new key) or
// the matching cell takes the new value (known key) while the result is
// loaded into the output register. A new request is taken once the apply
// cycle is done; the apply cycle waits only while an earlier result is
// still held on the result channel. The store is empty after reset with no
// clearing pass. An insert of a new key into a full store is rejected with
// status 1 and changes nothing.
module sorted_key_value_store_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key [31:0], value [63:32]
    input  logic [0:0]  s_tuser,   // opcode [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_value [31:0]
    output logic [1:0]  m_tuser    // found [0], status [1]
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_APPLY = 1'b1;

    logic                                state_reg, state_next;
    logic                                op_reg;
    logic signed [skvs_pkg::KEY_W-1:0]   key_reg;
    logic signed [skvs_pkg::VAL_W-1:0]   val_reg;
    logic                                m_valid_reg, m_valid_next;
    logic signed [skvs_pkg::VAL_W-1:0]   m_value_reg;
    logic                                m_found_reg;
    logic                                m_status_reg;

    logic                                in_acc;
    logic                                apply_go;
    logic                                hit;
    logic                                full;
    logic signed [skvs_pkg::VAL_W-1:0]   hit_value;
    skvs_pkg::apply_cmd_t                cmd;
    skvs_pkg::cell_out_t                 cells [skvs_pkg::CAPACITY];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign apply_go = (state_reg == ST_APPLY) && (!m_valid_reg || m_tready);
    assign full     = cells[skvs_pkg::CAPACITY-1].valid;

    always_comb begin
        hit       = 1'b0;
        hit_value = '0;
        for (int i = 0; i < skvs_pkg::CAPACITY; i++) begin
            hit       = hit | cells[i].eq;
            hit_value = hit_value | (cells[i].eq ? cells[i].value : '0);
        end
    end

    always_comb begin
        cmd.insert = apply_go && (op_reg == skvs_pkg::OP_INSERT) && !hit && !full;
        cmd.update = apply_go && (op_reg == skvs_pkg::OP_INSERT) && hit;
        cmd.key    = key_reg;
        cmd.value  = val_reg;
    end

    for (genvar i = 0; i < skvs_pkg::CAPACITY; i++) begin : g_cell
        skvs_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmp_en   (in_acc),
            .cmp_key  (s_tdata[skvs_pkg::KEY_W-1:0]),
            .cmd      (cmd),
            .prev     ((i == 0) ? skvs_pkg::CELL_EDGE : cells[(i == 0) ? 0 : i-1]),
            .slot_out (cells[i])
        );
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (apply_go) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (apply_go) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            op_reg  <= s_tuser[0];
            key_reg <= s_tdata[skvs_pkg::KEY_W-1:0];
            val_reg <= s_tdata[skvs_pkg::KEY_W +: skvs_pkg::VAL_W];
        end
        if (apply_go) begin
            m_value_reg  <= (op_reg == skvs_pkg::OP_QUERY) ? hit_value : '0;
            m_found_reg  <= hit;
            m_status_reg <= (op_reg == skvs_pkg::OP_INSERT && !hit && full)
                            ? skvs_pkg::STATUS_FULL : skvs_pkg::STATUS_OK;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = {m_status_reg, m_found_reg};

endmodule

[design/skvs_cell.sv]
module skvs_cell (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cmp_en,
    input  logic signed [skvs_pkg::KEY_W-1:0]    cmp_key,
    input  skvs_pkg::apply_cmd_t                 cmd,
    input  skvs_pkg::cell_out_t                  prev,
    output skvs_pkg::cell_out_t                  slot_out
);

    logic                                valid_reg, valid_next;
    logic                                lt_reg, lt_next;
    logic                                eq_reg, eq_next;
    logic signed [skvs_pkg::KEY_W-1:0]   key_reg, key_next;
    logic signed [skvs_pkg::VAL_W-1:0]   val_reg, val_next;
    logic                                is_pos;

    // first cell whose key is not below the request key
    assign is_pos = !lt_reg && prev.lt;

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        if (cmp_en) begin
            lt_next = valid_reg && (key_reg < cmp_key);
            eq_next = valid_reg && (key_reg == cmp_key);
        end
        if (cmd.insert && !lt_reg) begin
            if (is_pos) begin
                valid_next = 1'b1;
                key_next   = cmd.key;
                val_next   = cmd.value;
            end else begin
                // make room: take the lower neighbor's entry
                valid_next = prev.valid;
                key_next   = prev.key;
                val_next   = prev.value;
            end
        end
        if (cmd.update && eq_reg) begin
            val_next = cmd.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        val_reg <= val_next;
        lt_reg  <= lt_next;
        eq_reg  <= eq_next;
    end

    assign slot_out = '{valid: valid_reg, lt: lt_reg, eq: eq_reg,
                        key: key_reg, value: val_reg};

endmodule

[design/skvs_checker.sv]
module skvs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one request at a time: taking a request closes the input until it is applied
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a request");

    // a rejected insert never reports a present key
    a_reject_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("full status with found set");

    // a miss always reads zero
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
        else $error("nonzero value without a hit");

endmodule

bind sorted_key_value_store_unit skvs_checker u_skvs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
